// ----- rtl/core/uvs_pkg.sv -----
// uvs_pkg: shared widths, Q30 constants, command and register codes and the
// rounding Q30 multiply for the UV-sphere tessellator. No dependencies.
package uvs_pkg;

	localparam int Q_W   = 30;                 // angle and poly magnitudes below one
	localparam int MAG_W = 31;                 // magnitudes up to and including one

	localparam logic [MAG_W-1:0] ONE_Q30     = 31'h4000_0000;
	localparam logic [MAG_W-1:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [16:0]      TEX_ONE     = 17'h10000;

	// request commands
	localparam logic CMD_VERTEX = 1'b0;
	localparam logic CMD_CELL   = 1'b1;

	// register map
	localparam logic REG_STACK_COUNT = 1'b0;
	localparam logic REG_SLICE_COUNT = 1'b1;

	// long-division widths
	localparam int DIV_STAGES = 8;
	localparam int XNUM_W     = 38;            // rem * pi/2 + den/2
	localparam int XDEN_W     = 8;             // 2 * stacks or slices
	localparam int TNUM_W     = 23;            // n * 65536 + den/2
	localparam int TDEN_W     = 7;

	// (a * b + 2^29) >> 30
	function automatic logic [MAG_W-1:0] mulq(input logic [MAG_W-1:0] a,
			input logic [MAG_W-1:0] b);
		logic [2*MAG_W-1:0] p;
		p = (2*MAG_W)'(a) * (2*MAG_W)'(b);
		p = p + ((2*MAG_W)'(1) << 29);
		return p[60:30];
	endfunction

endpackage

// ----- rtl/core/uvs_delay.sv -----
// uvs_delay: enabled shift line that keeps side data aligned with the
// arithmetic pipeline. No dependencies.
module uvs_delay #(
	parameter int W = 8,
	parameter int N = 2
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_s [N];

	always_ff @(posedge clk) begin
		if (en) begin
			line_s[0] <= d;
			for (int k = 1; k < N; k++) begin
				line_s[k] <= line_s[k-1];
			end
		end
	end

	assign q = line_s[N-1];

endmodule

// ----- rtl/core/uvs_divider.sv -----
// uvs_divider: pipelined restoring divider, ceil(NW/STAGES) quotient bits per stage.
// No dependencies. Quotient must fit the padded width; remainder is dropped.
module uvs_divider #(
	parameter int NW     = 23,
	parameter int DW     = 7,
	parameter int STAGES = 8
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [NW-1:0]           num,
	input  logic [DW-1:0]           den,
	output logic [((NW+STAGES-1)/STAGES)*STAGES-1:0] quo
);

	localparam int STEPS = (NW + STAGES - 1) / STAGES;
	localparam int QW    = STEPS * STAGES;

	logic [QW-1:0] acc_s [STAGES];
	logic [DW-1:0] rem_s [STAGES];
	logic [DW-1:0] den_s [STAGES];

	logic [QW-1:0] acc_n [STAGES];
	logic [DW-1:0] rem_n [STAGES];
	logic [DW-1:0] den_n [STAGES];

	always_comb begin
		logic [QW-1:0] a;
		logic [DW:0]   r;
		logic [DW-1:0] d;
		for (int k = 0; k < STAGES; k++) begin
			if (k == 0) begin
				a = QW'(num);
				r = '0;
				d = den;
			end else begin
				a = acc_s[k-1];
				r = {1'b0, rem_s[k-1]};
				d = den_s[k-1];
			end
			for (int j = 0; j < STEPS; j++) begin
				r = {r[DW-1:0], a[QW-1]};
				a = {a[QW-2:0], 1'b0};
				if (r >= {1'b0, d}) begin
					r = r - {1'b0, d};
					a[0] = 1'b1;
				end
			end
			acc_n[k] = a;
			rem_n[k] = r[DW-1:0];
			den_n[k] = d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < STAGES; k++) begin
				acc_s[k] <= acc_n[k];
				rem_s[k] <= rem_n[k];
				den_s[k] <= den_n[k];
			end
		end
	end

	assign quo = acc_s[STAGES-1];

endmodule

// ----- rtl/core/uvs_cdiv.sv -----
// uvs_cdiv: registered truncating divide of a Q30 value by a constant,
// exact reciprocal multiply. No dependencies.
module uvs_cdiv #(
	parameter int K = 6
) (
	input  logic        clk,
	input  logic        en,
	input  logic [29:0] num,
	output logic [29:0] quo
);

	localparam int          L = $clog2(K);
	localparam int          S = 30 + L;
	localparam logic [30:0] M = 31'(((64'd1 << S) + K - 1) / K);

	logic [60:0] prod;
	logic [60:0] shifted;

	assign prod    = 61'(num) * 61'(M);
	assign shifted = prod >> S;

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= shifted[29:0];
		end
	end

endmodule

// ----- rtl/core/uvs_sincos.sv -----
// uvs_sincos: nine-stage Horner evaluation of sin and cos on [0, pi/4] in Q30.
// Depends on uvs_pkg, uvs_cdiv.
module uvs_sincos (
	input  logic                         clk,
	input  logic                         en,
	input  logic [uvs_pkg::Q_W-1:0]      x,
	output logic [uvs_pkg::MAG_W-1:0]    sin_mag,
	output logic [uvs_pkg::MAG_W-1:0]    cos_mag
);

	import uvs_pkg::*;

	logic [MAG_W-1:0] x2w;
	logic [Q_W-1:0]   x_s1, x_s2, x_s3, x_s4, x_s5, x_s6, x_s7, x_s8;
	logic [Q_W-1:0]   x2_s1, x2_s2, x2_s3, x2_s4, x2_s5, x2_s6, x2_s7, x2_s8;
	logic [Q_W-1:0]   qs_s2, qc_s2, qs_s4, qc_s4, qs_s6, qc_s6, qs_s8, qc_s8;
	logic [Q_W-1:0]   ps_s3, pc_s3, ps_s5, pc_s5, ps_s7, pc_s7;
	logic [MAG_W-1:0] s_s9, pc_s9;
	logic [MAG_W-1:0] ps3_w, pc3_w, ps5_w, pc5_w, ps7_w, pc7_w;

	assign x2w = mulq(MAG_W'(x), MAG_W'(x));

	// step terms: t = 1 - p/k, then p' = x2 * t
	assign ps3_w = mulq(MAG_W'(x2_s2), ONE_Q30 - MAG_W'(qs_s2));
	assign pc3_w = mulq(MAG_W'(x2_s2), ONE_Q30 - MAG_W'(qc_s2));
	assign ps5_w = mulq(MAG_W'(x2_s4), ONE_Q30 - MAG_W'(qs_s4));
	assign pc5_w = mulq(MAG_W'(x2_s4), ONE_Q30 - MAG_W'(qc_s4));
	assign ps7_w = mulq(MAG_W'(x2_s6), ONE_Q30 - MAG_W'(qs_s6));
	assign pc7_w = mulq(MAG_W'(x2_s6), ONE_Q30 - MAG_W'(qc_s6));

	uvs_cdiv #(.K(72)) u_ds72 (.clk(clk), .en(en), .num(x2_s1), .quo(qs_s2));
	uvs_cdiv #(.K(90)) u_dc90 (.clk(clk), .en(en), .num(x2_s1), .quo(qc_s2));
	uvs_cdiv #(.K(42)) u_ds42 (.clk(clk), .en(en), .num(ps_s3), .quo(qs_s4));
	uvs_cdiv #(.K(56)) u_dc56 (.clk(clk), .en(en), .num(pc_s3), .quo(qc_s4));
	uvs_cdiv #(.K(20)) u_ds20 (.clk(clk), .en(en), .num(ps_s5), .quo(qs_s6));
	uvs_cdiv #(.K(30)) u_dc30 (.clk(clk), .en(en), .num(pc_s5), .quo(qc_s6));
	uvs_cdiv #(.K(6))  u_ds6  (.clk(clk), .en(en), .num(ps_s7), .quo(qs_s8));
	uvs_cdiv #(.K(12)) u_dc12 (.clk(clk), .en(en), .num(pc_s7), .quo(qc_s8));

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= x;
			x2_s1 <= x2w[Q_W-1:0];
			x_s2  <= x_s1;  x2_s2 <= x2_s1;
			ps_s3 <= ps3_w[Q_W-1:0];
			pc_s3 <= pc3_w[Q_W-1:0];
			x_s3  <= x_s2;  x2_s3 <= x2_s2;
			x_s4  <= x_s3;  x2_s4 <= x2_s3;
			ps_s5 <= ps5_w[Q_W-1:0];
			pc_s5 <= pc5_w[Q_W-1:0];
			x_s5  <= x_s4;  x2_s5 <= x2_s4;
			x_s6  <= x_s5;  x2_s6 <= x2_s5;
			ps_s7 <= ps7_w[Q_W-1:0];
			pc_s7 <= pc7_w[Q_W-1:0];
			x_s7  <= x_s6;  x2_s7 <= x2_s6;
			x_s8  <= x_s7;  x2_s8 <= x2_s7;
			s_s9  <= mulq(MAG_W'(x_s8), ONE_Q30 - MAG_W'(qs_s8));
			pc_s9 <= mulq(MAG_W'(x2_s8), ONE_Q30 - MAG_W'(qc_s8));
		end
	end

	assign sin_mag = s_s9;
	assign cos_mag = ONE_Q30 - (pc_s9 >> 1);   // last Horner step divides by two

endmodule

// ----- rtl/core/uv_sphere_tessellator.sv -----
// UV-sphere tessellator: vertex and cell-triangle requests for a unit sphere.
// Throughput: one request per cycle; an inner-band cell takes two output beats.
// The rate is set by the single output register, which holds the pipe while
// a result waits. Reset: stack_count and slice_count go to 16, pipe empties.
module uv_sphere_tessellator #(
	parameter int MAX_STACKS      = 64,
	parameter int MAX_SLICES      = 64,
	parameter int COORD_FRAC_BITS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic [6:0]         cfg_data,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic [6:0]         ring_or_band,
	input  logic [6:0]         slice_pos,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] pos_x,
	output logic signed [15:0] pos_y,
	output logic signed [15:0] pos_z,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic [12:0]        index_a,
	output logic [12:0]        index_b,
	output logic [12:0]        index_c,
	output logic               range_error,
	output logic               last
);

	import uvs_pkg::*;

	localparam logic [1:0] KIND_POLE_N = 2'd0;
	localparam logic [1:0] KIND_POLE_S = 2'd1;
	localparam logic [1:0] KIND_RING   = 2'd2;
	localparam logic [1:0] KIND_TRI    = 2'd3;

	// clamp limits, fields are seven bits wide
	localparam logic [6:0] ST_HI = 7'((MAX_STACKS > 127) ? 127 : MAX_STACKS);
	localparam logic [6:0] SL_HI = 7'((MAX_SLICES > 127) ? 127 : MAX_SLICES);

	// output rounding from Q30
	localparam int               SH  = 30 - COORD_FRAC_BITS;
	localparam logic [MAG_W:0]   RND = (MAG_W+1)'((64'd1 << SH) >> 1);

	localparam int NPIPE = 21;     // r1 .. r21 ahead of the output register
	localparam int XQ_W  = ((XNUM_W + DIV_STAGES - 1) / DIV_STAGES) * DIV_STAGES;
	localparam int TQ_W  = ((TNUM_W + DIV_STAGES - 1) / DIV_STAGES) * DIV_STAGES;

	typedef struct packed {
		logic [1:0] quad;
		logic [7:0] rem;
		logic       swap;
	} quad_t;

	typedef struct packed {
		logic        err;
		logic [1:0]  kind;
		logic        two;
		logic [12:0] ia;
		logic [12:0] ib;
		logic [12:0] ic;
		logic [1:0]  ph_quad;
		logic        ph_swap;
		logic [1:0]  th_quad;
		logic        th_swap;
	} meta_t;

	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic             neg;
	} sval_t;

	// quadrant and fold of num/den turns; exact while 4*num < 8*den
	function automatic quad_t quad_split(input logic [6:0] num, input logic [7:0] den);
		quad_t       o;
		logic [9:0]  r;
		logic [9:0]  d1;
		o  = '0;
		r  = {1'b0, num, 2'b00};
		d1 = {2'b00, den};
		if (r >= (d1 << 2)) r = r - (d1 << 2);
		if (r >= (d1 << 1)) begin
			r = r - (d1 << 1);
			o.quad[1] = 1'b1;
		end
		if (r >= d1) begin
			r = r - d1;
			o.quad[0] = 1'b1;
		end
		o.rem = r[7:0];
		if ({o.rem, 1'b0} > {1'b0, den}) begin
			o.rem  = den - o.rem;
			o.swap = 1'b1;
		end
		return o;
	endfunction

	function automatic logic [15:0] to_out(input logic [MAG_W-1:0] mag, input logic neg);
		logic [MAG_W:0] m;
		m = ({1'b0, mag} + RND) >> SH;
		if (neg) m = -m;
		return m[15:0];
	endfunction

	// ------------------------------------------------------------------
	// configuration
	logic [6:0] stack_q, slice_q;
	logic [6:0] st, sl;
	logic [7:0] rl, den_ph, den_th;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_q <= 7'd16;
			slice_q <= 7'd16;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_STACK_COUNT: stack_q <= cfg_data;
				REG_SLICE_COUNT: slice_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// out-of-range values are kept but clamped here
	assign st     = (stack_q < 7'd2) ? 7'd2 : ((stack_q > ST_HI) ? ST_HI : stack_q);
	assign sl     = (slice_q < 7'd3) ? 7'd3 : ((slice_q > SL_HI) ? SL_HI : slice_q);
	assign rl     = {1'b0, sl} + 8'd1;
	assign den_ph = {st, 1'b0};
	assign den_th = {1'b0, sl};

	// ------------------------------------------------------------------
	// pipe control: one advance for the whole pipe
	logic             adv;
	logic [NPIPE-1:0] vld_q;
	logic             hold_v_q, two_q, second_q;

	assign adv      = !hold_v_q || (!out_stall && (!two_q || second_q));
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			hold_v_q <= 1'b0;
			second_q <= 1'b0;
		end else if (adv) begin
			vld_q    <= {vld_q[NPIPE-2:0], in_valid};
			hold_v_q <= vld_q[NPIPE-1];
			second_q <= 1'b0;
		end else if (hold_v_q && !out_stall && two_q && !second_q) begin
			second_q <= 1'b1;     // first triangle of an inner band taken
		end
	end

	// ------------------------------------------------------------------
	// r1: request capture
	logic       cmd_s1;
	logic [6:0] rb_s1, sp_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= command;
			rb_s1  <= ring_or_band;
			sp_s1  <= slice_pos;
		end
	end

	// r1 -> r2: classify, indices, quadrant split
	quad_t       qph_w, qth_w;
	meta_t       meta_n;
	logic [14:0] rowb, up, dn, south, base;

	assign qph_w = quad_split(rb_s1, den_ph);
	assign qth_w = quad_split(sp_s1, den_th);
	assign rowb  = 15'(rb_s1 - 7'd1) * 15'(rl);
	assign up    = rowb + 15'd1 + 15'(sp_s1);
	assign dn    = up + 15'(rl);
	assign south = 15'(st - 7'd1) * 15'(rl) + 15'd1;
	assign base  = south - 15'(rl);

	always_comb begin
		meta_n         = '0;
		meta_n.ph_quad = qph_w.quad;
		meta_n.ph_swap = qph_w.swap;
		meta_n.th_quad = qth_w.quad;
		meta_n.th_swap = qth_w.swap;
		if (cmd_s1 == CMD_VERTEX) begin
			if (rb_s1 > st || sp_s1 > sl) begin
				meta_n.err = 1'b1;
			end else if (rb_s1 == 7'd0) begin
				meta_n.kind = KIND_POLE_N;
			end else if (rb_s1 == st) begin
				meta_n.kind = KIND_POLE_S;
				meta_n.ia   = south[12:0];
			end else begin
				meta_n.kind = KIND_RING;
				meta_n.ia   = up[12:0];
			end
		end else begin
			meta_n.kind = KIND_TRI;
			if (rb_s1 >= st || sp_s1 >= sl) begin
				meta_n.err = 1'b1;
			end else if (rb_s1 == 7'd0) begin
				meta_n.ib = 13'(sp_s1) + 13'd2;
				meta_n.ic = 13'(sp_s1) + 13'd1;
			end else if (rb_s1 == st - 7'd1) begin
				meta_n.ia = south[12:0];
				meta_n.ib = base[12:0] + 13'(sp_s1);
				meta_n.ic = base[12:0] + 13'(sp_s1) + 13'd1;
			end else begin
				// inner band: second triangle is (dn, up+1, dn+1)
				meta_n.two = 1'b1;
				meta_n.ia  = up[12:0];
				meta_n.ib  = up[12:0] + 13'd1;
				meta_n.ic  = dn[12:0];
			end
		end
	end

	meta_t      meta_s2;
	logic [7:0] phrem_s2, threm_s2;
	logic [6:0] rb_s2, sp_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s2  <= meta_n;
			phrem_s2 <= qph_w.rem;
			threm_s2 <= qth_w.rem;
			rb_s2    <= rb_s1;
			sp_s2    <= sp_s1;
		end
	end

	// r3: dividends for angle and texture divides
	logic [XNUM_W-1:0] phnum_s3, thnum_s3;
	logic [TNUM_W-1:0] tunum_s3, tvnum_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			phnum_s3 <= XNUM_W'(phrem_s2) * XNUM_W'(HALF_PI_Q30) + XNUM_W'(den_ph >> 1);
			thnum_s3 <= XNUM_W'(threm_s2) * XNUM_W'(HALF_PI_Q30) + XNUM_W'(den_th >> 1);
			tunum_s3 <= {sp_s2, 16'h0000} + TNUM_W'(sl >> 1);
			tvnum_s3 <= {rb_s2, 16'h0000} + TNUM_W'(st >> 1);
		end
	end

	// r4 .. r11: long division
	logic [XQ_W-1:0] xph_q, xth_q;
	logic [TQ_W-1:0] tu_q, tv_q;

	uvs_divider #(.NW(XNUM_W), .DW(XDEN_W), .STAGES(DIV_STAGES)) u_div_ph (
		.clk(clk), .en(adv), .num(phnum_s3), .den(den_ph), .quo(xph_q));
	uvs_divider #(.NW(XNUM_W), .DW(XDEN_W), .STAGES(DIV_STAGES)) u_div_th (
		.clk(clk), .en(adv), .num(thnum_s3), .den(den_th), .quo(xth_q));
	uvs_divider #(.NW(TNUM_W), .DW(TDEN_W), .STAGES(DIV_STAGES)) u_div_tu (
		.clk(clk), .en(adv), .num(tunum_s3), .den(sl), .quo(tu_q));
	uvs_divider #(.NW(TNUM_W), .DW(TDEN_W), .STAGES(DIV_STAGES)) u_div_tv (
		.clk(clk), .en(adv), .num(tvnum_s3), .den(st), .quo(tv_q));

	// r12 .. r20: polynomials
	logic [MAG_W-1:0] sph_w, cph_w, sth_w, cth_w;

	uvs_sincos u_sc_ph (.clk(clk), .en(adv), .x(xph_q[Q_W-1:0]),
		.sin_mag(sph_w), .cos_mag(cph_w));
	uvs_sincos u_sc_th (.clk(clk), .en(adv), .x(xth_q[Q_W-1:0]),
		.sin_mag(sth_w), .cos_mag(cth_w));

	// side data to r20
	meta_t       meta_s20;
	logic [33:0] tex_s20;

	uvs_delay #(.W($bits(meta_t)), .N(18)) u_dly_meta (
		.clk(clk), .en(adv), .d(meta_s2), .q(meta_s20));
	uvs_delay #(.W(34), .N(9)) u_dly_tex (
		.clk(clk), .en(adv), .d({tu_q[16:0], tv_q[16:0]}), .q(tex_s20));

	// r20 -> r21: quadrant symmetry, coordinate products
	sval_t snph, csph, snth, csth;
	logic [MAG_W-1:0] sbph, cbph, sbth, cbth;

	assign sbph = meta_s20.ph_swap ? cph_w : sph_w;
	assign cbph = meta_s20.ph_swap ? sph_w : cph_w;
	assign sbth = meta_s20.th_swap ? cth_w : sth_w;
	assign cbth = meta_s20.th_swap ? sth_w : cth_w;

	always_comb begin
		case (meta_s20.ph_quad)
			2'd0:    begin snph = '{sbph, 1'b0}; csph = '{cbph, 1'b0}; end
			2'd1:    begin snph = '{cbph, 1'b0}; csph = '{sbph, 1'b1}; end
			2'd2:    begin snph = '{sbph, 1'b1}; csph = '{cbph, 1'b1}; end
			default: begin snph = '{cbph, 1'b1}; csph = '{sbph, 1'b0}; end
		endcase
		case (meta_s20.th_quad)
			2'd0:    begin snth = '{sbth, 1'b0}; csth = '{cbth, 1'b0}; end
			2'd1:    begin snth = '{cbth, 1'b0}; csth = '{sbth, 1'b1}; end
			2'd2:    begin snth = '{sbth, 1'b1}; csth = '{cbth, 1'b1}; end
			default: begin snth = '{cbth, 1'b1}; csth = '{sbth, 1'b0}; end
		endcase
	end

	sval_t       px_s21, py_s21, pz_s21;
	meta_t       meta_s21;
	logic [33:0] tex_s21;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s21   <= '{mulq(snph.mag, csth.mag), snph.neg ^ csth.neg};
			py_s21   <= csph;
			pz_s21   <= '{mulq(snph.mag, snth.mag), snph.neg ^ snth.neg};
			meta_s21 <= meta_s20;
			tex_s21  <= tex_s20;
		end
	end

	// r21 -> output register: rounding and result assembly
	logic [15:0] px_n, py_n, pz_n;
	logic [16:0] tu_n, tv_n;
	logic [12:0] ia_n, ib_n, ic_n;

	always_comb begin
		px_n = '0;
		py_n = '0;
		pz_n = '0;
		tu_n = '0;
		tv_n = '0;
		ia_n = meta_s21.ia;
		ib_n = meta_s21.ib;
		ic_n = meta_s21.ic;
		case (meta_s21.kind)
			KIND_POLE_N: py_n = to_out(ONE_Q30, 1'b0);
			KIND_POLE_S: begin
				py_n = to_out(ONE_Q30, 1'b1);
				tv_n = TEX_ONE;
			end
			KIND_RING: begin
				px_n = to_out(px_s21.mag, px_s21.neg);
				py_n = to_out(py_s21.mag, py_s21.neg);
				pz_n = to_out(pz_s21.mag, pz_s21.neg);
				tu_n = tex_s21[33:17];
				tv_n = tex_s21[16:0];
			end
			default: ;      // triangles carry indices only
		endcase
		if (meta_s21.err) begin
			px_n = '0; py_n = '0; pz_n = '0;
			tu_n = '0; tv_n = '0;
			ia_n = '0; ib_n = '0; ic_n = '0;
		end
	end

	logic signed [15:0] px_q, py_q, pz_q;
	logic [16:0]        tu_q2, tv_q2;
	logic [12:0]        ia_q, ib_q, ic_q;
	logic               err_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_q  <= px_n;
			py_q  <= py_n;
			pz_q  <= pz_n;
			tu_q2 <= tu_n;
			tv_q2 <= tv_n;
			ia_q  <= ia_n;
			ib_q  <= ib_n;
			ic_q  <= ic_n;
			err_q <= meta_s21.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_q <= 1'b0;
		end else if (adv) begin
			two_q <= meta_s21.two && !meta_s21.err;
		end
	end

	// second beat of an inner band reuses the first beat's corners
	assign out_valid   = hold_v_q;
	assign pos_x       = px_q;
	assign pos_y       = py_q;
	assign pos_z       = pz_q;
	assign tex_u       = tu_q2;
	assign tex_v       = tv_q2;
	assign index_a     = second_q ? ic_q : ia_q;
	assign index_b     = ib_q;
	assign index_c     = second_q ? (ic_q + 13'd1) : ic_q;
	assign range_error = err_q;
	assign last        = !two_q || second_q;

endmodule
